### rtl/esc_pkg.sv
package esc_pkg;

  // Division constants, pre-sized to the 32-bit datapath
  localparam logic [31:0] DAY_SECS  = 32'd86400;
  localparam logic [31:0] HOUR_SECS = 32'd3600;
  localparam logic [31:0] MIN_SECS  = 32'd60;
  localparam logic [31:0] WEEK_DAYS = 32'd7;

  localparam logic [31:0] YEAR_DAYS      = 32'd365;
  localparam logic [31:0] LEAP_YEAR_DAYS = 32'd366;

  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [6:0]  BASE_YEAR_100 = 7'd70;   // 1970 mod 100
  localparam logic [8:0]  BASE_YEAR_400 = 9'd370;  // 1970 mod 400

  // Quotient bits minus one for each restoring division pass
  localparam logic [3:0] DAY_LAST_BIT  = 4'd15;  // days < 2^16
  localparam logic [3:0] HOUR_LAST_BIT = 4'd4;   // hour < 2^5
  localparam logic [3:0] MIN_LAST_BIT  = 4'd5;   // minute < 2^6
  localparam logic [3:0] WEEK_LAST_BIT = 4'd12;  // (days + 4) / 7 < 2^13

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_WEEK,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
  } request_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [8:0]  year_day;
    logic [3:0]  month;
    logic [4:0]  month_day;
  } result_t;

  // Status back from the shared subtractor
  typedef struct packed {
    logic [31:0] diff;
    logic        ge;
  } sub_res_t;

  function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
    logic [8:0] len;
    case (month)
      4'd0:    len = 9'd31;
      4'd1:    len = leap ? 9'd29 : 9'd28;
      4'd2:    len = 9'd31;
      4'd3:    len = 9'd30;
      4'd4:    len = 9'd31;
      4'd5:    len = 9'd30;
      4'd6:    len = 9'd31;
      4'd7:    len = 9'd31;
      4'd8:    len = 9'd30;
      4'd9:    len = 9'd31;
      4'd10:   len = 9'd30;
      4'd11:   len = 9'd31;
      default: len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/esc_stream_if.sv
interface esc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/esc_sub_unit.sv
module esc_sub_unit (
  input  logic [31:0]       op_a,
  input  logic [31:0]       op_b,
  output esc_pkg::sub_res_t res
);
  import esc_pkg::*;

  logic [32:0] wide_diff;

  // One subtract; no borrow means op_a >= op_b
  assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff  = wide_diff[31:0];
  assign res.ge    = ~wide_diff[32];
endmodule

### rtl/epoch_seconds_to_calendar_core.sv
// Epoch seconds to UTC calendar converter.
//
// request (sink): one 32-bit unsigned count of seconds since 1970-01-01 UTC.
// result (source): second, minute, hour, weekday, full year, day of year,
// month and day of month for that count.
//
// A request is taken only while the sequencer is idle. One shared 32-bit
// subtract/compare unit then does all the work, one step per cycle:
//   16 steps  seconds / 86400 (restoring division)
//    5 steps  seconds-in-day / 3600
//    6 steps  remainder / 60
//   13 steps  (days + 4) / 7 for the weekday
//   1..137    year steps, taking 365 or 366 days each
//   1..12     month steps
// plus a final step that loads the output register; late dates take longest,
// and the next request can be taken the cycle after that load. The result
// sits in an output register until taken, so a new request can be accepted
// while the receiver stalls; a finished conversion then waits in its last
// state until the output register frees.
// Reset (synchronous) returns the sequencer to idle and drops result valid.
module epoch_seconds_to_calendar_core (
  input  logic         clk,
  input  logic         rst,
  esc_stream_if.sink   request,
  esc_stream_if.source result
);
  import esc_pkg::*;

  state_t      state;
  state_t      state_next;

  // Working registers
  logic [31:0] rem;        // running remainder / day count
  logic [15:0] quo;        // quotient shift register
  logic [3:0]  cnt;        // quotient bit being resolved
  logic [15:0] days;
  logic [11:0] year;
  logic [6:0]  year_100;   // year mod 100
  logic [8:0]  year_400;   // year mod 400
  logic [3:0]  month;
  logic [8:0]  year_day;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;

  result_t     out_data;
  logic        out_valid;

  logic [31:0] op_b;
  sub_res_t    sub;
  logic [31:0] rem_step;
  logic [15:0] quo_step;
  logic        leap;
  logic        accept;
  logic        load;

  esc_sub_unit u_sub (
    .op_a (rem),
    .op_b (op_b),
    .res  (sub)
  );

  // Gregorian rule from running residues, no division needed
  assign leap = (year[1:0] == 2'b00) && ((year_100 != 7'd0) || (year_400 == 9'd0));

  assign rem_step = sub.ge ? sub.diff : rem;
  assign quo_step = {quo[14:0], sub.ge};

  assign accept = request.valid && request.ready;
  assign load   = (state == ST_DONE) && (!out_valid || result.ready);

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Operand select for the shared unit
  always_comb begin
    case (state)
      ST_DAY:   op_b = DAY_SECS << cnt;
      ST_HOUR:  op_b = HOUR_SECS << cnt;
      ST_MIN:   op_b = MIN_SECS << cnt;
      ST_WEEK:  op_b = WEEK_DAYS << cnt;
      ST_YEAR:  op_b = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
      ST_MONTH: op_b = {23'd0, month_len(month, leap)};
      default:  op_b = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and handshake
  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) state_next = ST_DAY;
      end
      ST_DAY:   if (cnt == 4'd0) state_next = ST_HOUR;
      ST_HOUR:  if (cnt == 4'd0) state_next = ST_MIN;
      ST_MIN:   if (cnt == 4'd0) state_next = ST_WEEK;
      ST_WEEK:  if (cnt == 4'd0) state_next = ST_YEAR;
      ST_YEAR:  if (!sub.ge) state_next = ST_MONTH;
      ST_MONTH: if (!sub.ge || month == MONTH_DEC) state_next = ST_DONE;
      ST_DONE:  if (load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rem <= request.data.epoch_seconds;
          cnt <= DAY_LAST_BIT;
        end
      end
      ST_DAY: begin
        rem <= rem_step;
        quo <= quo_step;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          days <= quo_step;
          cnt  <= HOUR_LAST_BIT;
        end
      end
      ST_HOUR: begin
        rem <= rem_step;
        quo <= quo_step;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          hour <= quo_step[4:0];
          cnt  <= MIN_LAST_BIT;
        end
      end
      ST_MIN: begin
        rem <= rem_step;
        quo <= quo_step;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          minute <= quo_step[5:0];
          second <= rem_step[5:0];
          // day 0 was a Thursday
          rem    <= {16'd0, days} + 32'd4;
          cnt    <= WEEK_LAST_BIT;
        end
      end
      ST_WEEK: begin
        rem <= rem_step;
        quo <= quo_step;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          weekday  <= rem_step[2:0];
          rem      <= {16'd0, days};
          year     <= BASE_YEAR;
          year_100 <= BASE_YEAR_100;
          year_400 <= BASE_YEAR_400;
        end
      end
      ST_YEAR: begin
        if (sub.ge) begin
          rem      <= sub.diff;
          year     <= year + 12'd1;
          year_100 <= (year_100 == 7'd99) ? 7'd0 : year_100 + 7'd1;
          year_400 <= (year_400 == 9'd399) ? 9'd0 : year_400 + 9'd1;
        end else begin
          year_day <= rem[8:0];
          month    <= MONTH_JAN;
        end
      end
      ST_MONTH: begin
        // leave the month only once the day index reaches its length
        if (sub.ge && month != MONTH_DEC) begin
          rem   <= sub.diff;
          month <= month + 4'd1;
        end
      end
      ST_DONE: begin
        if (load) begin
          out_data.second    <= second;
          out_data.minute    <= minute;
          out_data.hour      <= hour;
          out_data.weekday   <= weekday;
          out_data.year      <= year;
          out_data.year_day  <= year_day;
          out_data.month     <= month;
          out_data.month_day <= rem[4:0] + 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (year <= 12'd2106))
    else $error("year step ran past 2106");

  a_hour_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOUR) |-> (rem < DAY_SECS))
    else $error("seconds in day out of range");

  a_month_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (rem < LEAP_YEAR_DAYS))
    else $error("day of year out of range in month step");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not flagged valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !result.ready) |=> (state == ST_DONE))
    else $error("finished conversion left while output stalled");
`endif
endmodule
